### sv/local_max_count_average_top_assert.svh
// Assertion macros used by the top-level RTL file of the local maximum counter.
`ifndef LOCAL_MAX_COUNT_AVERAGE_TOP_ASSERT_SVH
`define LOCAL_MAX_COUNT_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define LMCA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmca: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define LMCA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmca: next-cycle check failed");

`endif

### sv/lmca_pkg.sv
package lmca_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int PIX_BITS   = 16;
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int DIM_BITS   = 11;
  localparam int CNT_BITS   = 19;
  localparam int SUM_BITS   = 34;
  localparam int AVG_BITS   = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_BITS  = $clog2(SUM_BITS + 1);

  // 3x3 window, indexed [column: oldest..newest][row: top..bottom]
  typedef logic [2:0][2:0][PIX_BITS-1:0] win_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/local_max_count_average_top.sv
// Channel   | Handshake           | Payload
// ----------+---------------------+-------------------------------------------
// in        | in_valid/in_ready   | in_pixel_value (16b, raster order)
// out       | out_valid/out_ready | out_peak_count, out_peak_sum, out_peak_average
// cfg       | cfg_we (no wait)    | cfg_index, cfg_data
//
// Each pixel is accepted in S_IDLE, where both line stores are read, and is
// used in S_UPD to update the window, line stores and totals. After the last
// pixel of a frame the block runs a serial divide in S_DIV, then loads the
// result register in S_EMIT; no input is taken in that time.
// rst_n is synchronous; line stores are not cleared and need no clearing pass.
// A waiting result does not stop the next frame; only the following frame end
// stalls, until the result register is taken.
module local_max_count_average_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lmca_pkg::PIX_BITS-1:0]  in_pixel_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lmca_pkg::CNT_BITS-1:0]  out_peak_count,
  output logic [lmca_pkg::SUM_BITS-1:0]  out_peak_sum,
  output logic [lmca_pkg::AVG_BITS-1:0]  out_peak_average,
  input  logic                           cfg_we,
  input  logic [lmca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmca_pkg::CFG_W-1:0]     cfg_data
);
  import lmca_pkg::*;

  `include "local_max_count_average_top_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [PIX_BITS-1:0] thr_r;
  logic [DIM_BITS-1:0] width_r;
  logic [DIM_BITS-1:0] height_r;
  logic [DIM_BITS-1:0] w_eff;
  logic [DIM_BITS-1:0] h_eff;

  // frame position and accumulators
  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt, count_acc;
  logic [SUM_BITS-1:0] sum_r, sum_nxt, sum_acc;
  win_t                win_r, win_nxt, win_sh;

  logic [PIX_BITS-1:0] pix_r;
  logic [PIX_BITS-1:0] upper_q;
  logic [PIX_BITS-1:0] middle_q;

  logic                last_col;
  logic                last_row;
  logic                frame_end;
  logic [2:0]          col_ok;
  logic [2:0]          row_ok;
  logic [3:0]          judge_en;
  logic [2:0]          cnt_inc;
  logic [PIX_BITS+1:0] sum_inc;

  // frame totals kept for the result
  logic [CNT_BITS-1:0] fin_count_r;
  logic [SUM_BITS-1:0] fin_sum_r;

  div_stat_t           div_stat;
  logic [AVG_BITS-1:0] div_quo;
  logic                div_start;

  logic                out_valid_r;
  logic                out_load;
  logic [CNT_BITS-1:0] out_count_r;
  logic [SUM_BITS-1:0] out_sum_r;
  logic [AVG_BITS-1:0] out_avg_r;

  logic                in_accept;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Configuration: plain write port, unknown indexes dropped
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      width_r  <= DIM_BITS'(MAX_COLS);
      height_r <= DIM_BITS'(MAX_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r    <= cfg_data[PIX_BITS-1:0];
        CFG_WIDTH:     width_r  <= cfg_data[DIM_BITS-1:0];
        CFG_HEIGHT:    height_r <= cfg_data[DIM_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // Clamp geometry: zero acts as one, oversize acts as the store depth
  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_BITS'(1);
    end else if (width_r > DIM_BITS'(MAX_COLS)) begin
      w_eff = DIM_BITS'(MAX_COLS);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_BITS'(1);
    end else if (height_r > DIM_BITS'(MAX_ROWS)) begin
      h_eff = DIM_BITS'(MAX_ROWS);
    end else begin
      h_eff = height_r;
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: read on the accepting edge, write back in the update cycle
  // ---------------------------------------------------------------------
  lmca_line_store u_line_store (
    .clk      (clk),
    .rd_en    (in_accept),
    .wr_en    (state_r == S_UPD),
    .addr     (col_r),
    .wr_pixel (pix_r),
    .upper_q  (upper_q),
    .middle_q (middle_q)
  );

  // Hold the accepted pixel for the update cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pix_r <= in_pixel_value;
    end
  end

  // ---------------------------------------------------------------------
  // Window shift and judging of every centre whose last neighbour is in
  // ---------------------------------------------------------------------
  assign last_col  = (DIM_BITS'(col_r) + DIM_BITS'(1)) >= w_eff;
  assign last_row  = (DIM_BITS'(row_r) + DIM_BITS'(1)) >= h_eff;
  assign frame_end = last_col && last_row;

  always_comb begin
    win_sh       = win_r;
    win_sh[0]    = win_r[1];
    win_sh[1]    = win_r[2];
    win_sh[2][0] = upper_q;
    win_sh[2][1] = middle_q;
    win_sh[2][2] = pix_r;
  end

  assign col_ok   = {1'b1, col_r != '0, col_r >= COL_BITS'(2)};
  assign row_ok   = {1'b1, row_r != '0, row_r >= ROW_BITS'(2)};
  // centres: middle, right column at row end, bottom row, bottom-right corner
  assign judge_en = {last_row && last_col,
                     last_row && col_ok[1],
                     last_col && row_ok[1],
                     col_ok[1] && row_ok[1]};

  lmca_judge u_judge (
    .win       (win_sh),
    .col_ok    (col_ok),
    .row_ok    (row_ok),
    .judge_en  (judge_en),
    .threshold (thr_r),
    .cnt_inc   (cnt_inc),
    .sum_inc   (sum_inc)
  );

  assign count_acc = count_r + CNT_BITS'(cnt_inc);
  assign sum_acc   = sum_r + SUM_BITS'(sum_inc);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign div_start = (state_r == S_UPD) && frame_end;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    win_nxt   = win_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        count_nxt = count_acc;
        sum_nxt   = sum_acc;
        win_nxt   = win_sh;
        state_nxt = S_IDLE;
        if (!last_col) begin
          col_nxt = col_r + COL_BITS'(1);
        end else begin
          // row ends: restart the column and flush the window
          col_nxt = '0;
          win_nxt = '0;
          if (!last_row) begin
            row_nxt = row_r + ROW_BITS'(1);
          end else begin
            row_nxt   = '0;
            count_nxt = '0;
            sum_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      win_r   <= win_nxt;
    end
  end

  // Latch the frame totals as the divide starts
  always_ff @(posedge clk) begin
    if (div_start) begin
      fin_count_r <= count_acc;
      fin_sum_r   <= sum_acc;
    end
  end

  lmca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_acc),
    .divisor  (count_acc),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------
  // Result register: decouples the frame end from the consumer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= fin_count_r;
      out_sum_r   <= fin_sum_r;
      // no maxima: average reads zero
      out_avg_r   <= (fin_count_r == '0) ? '0 : div_quo;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_peak_count   = out_count_r;
  assign out_peak_sum     = out_sum_r;
  assign out_peak_average = out_avg_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `LMCA_ASSERT_IMPL(a_ready_not_dividing, clk, rst_n, in_ready, !div_stat.busy)
  `LMCA_ASSERT_IMPL(a_done_in_div, clk, rst_n, div_stat.done, state_r == S_DIV)
  `LMCA_ASSERT_NEXT(a_end_to_div, clk, rst_n, div_start, state_r == S_DIV)
  `LMCA_ASSERT_NEXT(a_end_clears, clk, rst_n, div_start, count_r == '0 && row_r == '0)

endmodule

### sv/lmca_line_store.sv
module lmca_line_store (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic                          wr_en,
  input  logic [lmca_pkg::COL_BITS-1:0] addr,
  input  logic [lmca_pkg::PIX_BITS-1:0] wr_pixel,
  output logic [lmca_pkg::PIX_BITS-1:0] upper_q,
  output logic [lmca_pkg::PIX_BITS-1:0] middle_q
);
  import lmca_pkg::*;

  logic [PIX_BITS-1:0] upper_mem  [MAX_COLS];
  logic [PIX_BITS-1:0] middle_mem [MAX_COLS];

  // write back shifts the column down: middle moves to upper, new pixel into middle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[addr]  <= middle_q;
      middle_mem[addr] <= wr_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q  <= upper_mem[addr];
      middle_q <= middle_mem[addr];
    end
  end

endmodule

### sv/lmca_judge.sv
module lmca_judge (
  input  lmca_pkg::win_t                win,
  input  logic [2:0]                    col_ok,
  input  logic [2:0]                    row_ok,
  input  logic [3:0]                    judge_en,
  input  logic [lmca_pkg::PIX_BITS-1:0] threshold,
  output logic [2:0]                    cnt_inc,
  output logic [lmca_pkg::PIX_BITS+1:0] sum_inc
);
  import lmca_pkg::*;

  logic [3:0] peak;

  function automatic logic is_peak(win_t w, int cc, int rr, logic [2:0] cok,
                                   logic [2:0] rok, logic [PIX_BITS-1:0] thr);
    logic                peak_f;
    logic [PIX_BITS-1:0] p;
    p      = w[cc][rr];
    peak_f = (p > thr);
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (!(c == cc && r == rr) && c >= cc - 1 && c <= cc + 1 &&
            r >= rr - 1 && r <= rr + 1 && cok[c] && rok[r] && w[c][r] >= p) begin
          peak_f = 1'b0;
        end
      end
    end
    return peak_f;
  endfunction

  always_comb begin
    peak[0] = judge_en[0] && is_peak(win, 1, 1, col_ok, row_ok, threshold);
    peak[1] = judge_en[1] && is_peak(win, 2, 1, col_ok, row_ok, threshold);
    peak[2] = judge_en[2] && is_peak(win, 1, 2, col_ok, row_ok, threshold);
    peak[3] = judge_en[3] && is_peak(win, 2, 2, col_ok, row_ok, threshold);
    cnt_inc = 3'(peak[0]) + 3'(peak[1]) + 3'(peak[2]) + 3'(peak[3]);
    sum_inc = (peak[0] ? (PIX_BITS+2)'(win[1][1]) : '0)
            + (peak[1] ? (PIX_BITS+2)'(win[2][1]) : '0)
            + (peak[2] ? (PIX_BITS+2)'(win[1][2]) : '0)
            + (peak[3] ? (PIX_BITS+2)'(win[2][2]) : '0);
  end

endmodule

### sv/lmca_div.sv
module lmca_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lmca_pkg::SUM_BITS-1:0] dividend,
  input  logic [lmca_pkg::CNT_BITS-1:0] divisor,
  output lmca_pkg::div_stat_t           stat,
  output logic [lmca_pkg::AVG_BITS-1:0] quotient
);
  import lmca_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_BITS-1:0] step_r;
  logic [CNT_BITS-1:0]  rem_r;
  logic [SUM_BITS-1:0]  quo_r;
  logic [CNT_BITS-1:0]  divisor_r;
  logic [CNT_BITS:0]    rem_sh;
  logic                 ge;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem_r, quo_r[SUM_BITS-1]};
  assign ge     = rem_sh >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_BITS'(SUM_BITS);
      end else if (busy_r) begin
        step_r <= step_r - STEP_BITS'(1);
        if (step_r == STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      quo_r     <= dividend;
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? CNT_BITS'(rem_sh - {1'b0, divisor_r}) : rem_sh[CNT_BITS-1:0];
      quo_r <= {quo_r[SUM_BITS-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r[AVG_BITS-1:0];

endmodule

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmca_pkg::*;

  localparam int SETTLE_CYCLES = 48;   // covers the serial divide plus margin
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off, spans several 1x1 frames
  localparam int QUIET_LIMIT   = 2000; // cycles without any transaction before giving up

  // Ways of filling a frame with pixel values
  typedef enum int {
    STYLE_NOISE,   // full-range random values
    STYLE_TIES,    // narrow band, many equal neighbours
    STYLE_SPARSE,  // low background with rare high spikes
    STYLE_FLAT,    // one value everywhere: a plateau
    STYLE_EDGE     // values straddling the threshold
  } pix_style_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] peak_count;
    logic [SUM_BITS-1:0] peak_sum;
    logic [AVG_BITS-1:0] peak_average;
  } frame_totals_t;

  // DUT ports; every input starts from a known value
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [PIX_BITS-1:0]  in_pixel_value = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [CNT_BITS-1:0]  out_peak_count;
  logic [SUM_BITS-1:0]  out_peak_sum;
  logic [AVG_BITS-1:0]  out_peak_average;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = CFG_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data       = '0;

  // Traffic shaping, set per phase by the stimulus
  int send_idle_max = 0;
  int recv_idle_max = 0;
  int send_gap      = 0;
  int recv_wait     = 0;
  logic recv_armed  = 1'b0;
  int hold_left     = 0;
  int holds_asked   = 0;
  int holds_served  = 0;

  // Pixels waiting to be offered, and frame totals waiting to come out
  logic [PIX_BITS-1:0] pending_pixels_q [$];
  frame_totals_t       frame_totals_q [$];

  // Local copy of the register file
  logic [PIX_BITS-1:0] peak_floor = '0;
  logic [DIM_BITS-1:0] cols_cfg   = DIM_BITS'(MAX_COLS);
  logic [DIM_BITS-1:0] rows_cfg   = DIM_BITS'(MAX_ROWS);

  // Local copy of the block's state: two line stores, the 3x3 window,
  // the raster position and the running totals
  logic [PIX_BITS-1:0] line_above2 [MAX_COLS];
  logic [PIX_BITS-1:0] line_above1 [MAX_COLS];
  win_t                nbhd         = '0;
  int                  col_pos      = 0;
  int                  row_pos      = 0;
  logic [SUM_BITS-1:0] peak_sum_acc = '0;
  logic [CNT_BITS-1:0] peak_cnt_acc = '0;

  // Bookkeeping
  int failures         = 0;
  int pixels_taken     = 0;
  int results_seen     = 0;
  int frames_with_peak = 0;
  int settings_applied = 0;
  int quiet_cycles     = 0;

  // Directed pixels, consumed in order by the opening phases
  logic [PIX_BITS-1:0] directed_px [21] = '{
    16'hFFFF, 16'h0000, 16'h0001,                       // three 1x1 frames
    16'd10, 16'd20, 16'd30, 16'd40, 16'd100, 16'd50,    // 3x3, centre peak
    16'd60, 16'd70, 16'd99,
    16'd7, 16'd7, 16'd7, 16'd7,                         // 2x2 plateau
    16'hFFFF,                                           // 1x1 at full threshold
    16'd5, 16'd9, 16'd9, 16'd2                          // single row, equal pair
  };
  int directed_pos = 0;

  local_max_count_average_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_peak_count   (out_peak_count),
    .out_peak_sum     (out_peak_sum),
    .out_peak_average (out_peak_average),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Print one line per mismatch and count every one
  task automatic note_failure(input string msg);
    failures++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Zero acts as one, anything above the store depth acts as the depth
  function automatic int clamp_dim(input logic [DIM_BITS-1:0] d, input int cap);
    if (d == '0) return 1;
    if (int'(d) > cap) return cap;
    return int'(d);
  endfunction

  // Judge the window pixel at [cc][rr] against the neighbours that lie in the frame
  function automatic void judge_centre(input int cc, input int rr,
                                       input logic [2:0] col_ok, input logic [2:0] row_ok);
    logic [PIX_BITS-1:0] centre;
    logic                is_peak;
    int                  c;
    int                  r;
    centre  = nbhd[cc][rr];
    is_peak = 1'b1;
    for (c = cc - 1; c <= cc + 1; c++) begin
      for (r = rr - 1; r <= rr + 1; r++) begin
        if ((c != cc || r != rr) && c >= 0 && c <= 2 && r >= 0 && r <= 2) begin
          if (col_ok[c] && row_ok[r] && nbhd[c][r] >= centre) is_peak = 1'b0;
        end
      end
    end
    if (is_peak && centre > peak_floor) begin
      peak_sum_acc = peak_sum_acc + SUM_BITS'(centre);
      peak_cnt_acc = peak_cnt_acc + CNT_BITS'(1);
    end
  endfunction

  // Advance the local copy by one accepted pixel; queue the totals at frame end
  function automatic void track_pixel(input logic [PIX_BITS-1:0] pix);
    int            w;
    int            h;
    int            idx;
    int            i;
    logic          last_col;
    logic          last_row;
    logic [2:0]    col_ok;
    logic [2:0]    row_ok;
    frame_totals_t totals;
    w        = clamp_dim(cols_cfg, MAX_COLS);
    h        = clamp_dim(rows_cfg, MAX_ROWS);
    idx      = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;

    // shift the window left, bring in the new column from the line stores
    for (i = 0; i < 3; i++) begin
      nbhd[0][i] = nbhd[1][i];
      nbhd[1][i] = nbhd[2][i];
    end
    nbhd[2][0]       = line_above2[idx];
    nbhd[2][1]       = line_above1[idx];
    nbhd[2][2]       = pix;
    line_above2[idx] = line_above1[idx];
    line_above1[idx] = pix;

    col_ok = {1'b1, col_pos >= 1, col_pos >= 2};
    row_ok = {1'b1, row_pos >= 1, row_pos >= 2};

    // judge each pixel once its last neighbour is in
    if (col_pos >= 1 && row_pos >= 1) judge_centre(1, 1, col_ok, row_ok);
    if (last_col && row_pos >= 1)     judge_centre(2, 1, col_ok, row_ok);
    if (last_row && col_pos >= 1)     judge_centre(1, 2, col_ok, row_ok);
    if (last_row && last_col)         judge_centre(2, 2, col_ok, row_ok);

    if (!last_col) begin
      col_pos = col_pos + 1;
    end else begin
      col_pos = 0;
      nbhd    = '0;
      if (!last_row) begin
        row_pos = row_pos + 1;
      end else begin
        totals.peak_count   = peak_cnt_acc;
        totals.peak_sum     = peak_sum_acc;
        totals.peak_average = (peak_cnt_acc != '0) ?
                              AVG_BITS'(peak_sum_acc / SUM_BITS'(peak_cnt_acc)) : '0;
        frame_totals_q.push_back(totals);
        row_pos      = 0;
        peak_sum_acc = '0;
        peak_cnt_acc = '0;
      end
    end
  endfunction

  // Compare one result transaction with the oldest frame waiting
  task automatic check_totals();
    frame_totals_t want;
    results_seen++;
    if (frame_totals_q.size() == 0) begin
      note_failure($sformatf("result %0d with no frame pending (count %0d sum %0d avg %0d)",
                             results_seen, out_peak_count, out_peak_sum, out_peak_average));
      return;
    end
    want = frame_totals_q.pop_front();
    if (want.peak_count != '0) frames_with_peak++;
    if (out_peak_count !== want.peak_count)
      note_failure($sformatf("result %0d peak_count %0d, want %0d",
                             results_seen, out_peak_count, want.peak_count));
    if (out_peak_sum !== want.peak_sum)
      note_failure($sformatf("result %0d peak_sum %0d, want %0d",
                             results_seen, out_peak_sum, want.peak_sum));
    if (out_peak_average !== want.peak_average)
      note_failure($sformatf("result %0d peak_average %0d, want %0d",
                             results_seen, out_peak_average, want.peak_average));
  endtask

  // Pixel driver: offer pixels from the pending queue; hold each one until
  // taken, then idle for the number of cycles drawn when it was loaded
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_pixel_value <= '0;
      send_gap       <= 0;
    end else begin
      if (in_valid && in_ready) begin
        track_pixel(in_pixel_value);
        pixels_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold: payload stays put until the transaction completes
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pixels_q.size() != 0) begin
        in_valid       <= 1'b1;
        in_pixel_value <= pending_pixels_q.pop_front();
        send_gap       <= $urandom_range(0, send_idle_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: once a result shows up, draw how long to wait before
  // taking it; between results, raise ready now and then so that a result
  // can also meet a ready that is already high
  always @(posedge clk) begin : recv_side
    int draw;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_armed <= 1'b0;
      recv_wait  <= 0;
    end else if (out_valid && out_ready) begin
      check_totals();
      out_ready  <= 1'b0;
      recv_armed <= 1'b0;
    end else if (out_valid && !recv_armed) begin
      draw       = $urandom_range(0, recv_idle_max);
      recv_armed <= 1'b1;
      recv_wait  <= draw;
      out_ready  <= (draw == 0) && (hold_left == 0);
    end else if (recv_armed) begin
      if (recv_wait != 0) recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait <= 1) && (hold_left == 0);
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
    end
  end

  // Long hold-off on the result side, counted here once the stimulus asks
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: give up after too long without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction, %0d frames still owed",
               QUIET_LIMIT, frame_totals_q.size());
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every pixel is taken and every frame result is back, then
  // let the divider settle before touching the registers
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels_q.size() != 0 || in_valid || frame_totals_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_THRESHOLD: peak_floor = data;
      CFG_WIDTH:     cols_cfg   = data[DIM_BITS-1:0];
      default:       rows_cfg   = data[DIM_BITS-1:0];
    endcase
  endtask

  // Drain, then write all three registers; returns at a falling edge
  task automatic apply_setting(input logic [CFG_W-1:0] thr,
                               input logic [CFG_W-1:0] wcode,
                               input logic [CFG_W-1:0] hcode);
    wait_drained();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_WIDTH, wcode);
    write_reg(CFG_HEIGHT, hcode);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_applied++;
  endtask

  task automatic queue_directed(input int n);
    repeat (n) begin
      pending_pixels_q.push_back(directed_px[directed_pos]);
      directed_pos++;
    end
  endtask

  function automatic logic [PIX_BITS-1:0] draw_pixel(input pix_style_t style, input int level);
    int v;
    case (style)
      STYLE_TIES:   v = level + int'($urandom_range(0, 2));
      STYLE_SPARSE: v = ($urandom_range(0, 5) == 0) ? int'($urandom_range(level, 65535))
                                                     : int'($urandom_range(0, level));
      STYLE_FLAT:   v = level;
      STYLE_EDGE:   v = level + int'($urandom_range(0, 4)) - 2;
      default:      v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return PIX_BITS'(v);
  endfunction

  // Queue one frame in a randomly chosen style; returns its pixel count
  function automatic int queue_frame(input int cols, input int rows);
    pix_style_t style;
    int         level;
    int         i;
    style = pix_style_t'($urandom_range(0, 4));
    case (style)
      STYLE_SPARSE: level = $urandom_range(0, 2000);
      STYLE_EDGE:   level = int'(peak_floor);
      default:      level = $urandom_range(0, 65535);
    endcase
    // a few extreme plateaus
    if (style == STYLE_FLAT && $urandom_range(0, 3) == 0)
      level = ($urandom_range(0, 1) != 0) ? 65535 : 0;
    for (i = 0; i < cols * rows; i++) pending_pixels_q.push_back(draw_pixel(style, level));
    return cols * rows;
  endfunction

  // Mostly tiny frames; zero now and then; junk in the unused upper bits
  function automatic logic [CFG_W-1:0] dim_code();
    logic [CFG_W-1:0] code;
    code = '0;
    case ($urandom_range(0, 7))
      0:       code[DIM_BITS-1:0] = '0;
      1:       code[DIM_BITS-1:0] = DIM_BITS'(1);
      2, 3:    code[DIM_BITS-1:0] = DIM_BITS'($urandom_range(2, 3));
      default: code[DIM_BITS-1:0] = DIM_BITS'($urandom_range(1, 9));
    endcase
    if ($urandom_range(0, 3) == 0) code[CFG_W-1:DIM_BITS] = (CFG_W - DIM_BITS)'($urandom_range(0, 31));
    return code;
  endfunction

  function automatic logic [CFG_W-1:0] threshold_code();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_W'($urandom_range(0, 2000));
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Idle profile for one side: none, heavy, or anything in between
  function automatic int idle_profile();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 11;
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0] wcode;
    logic [CFG_W-1:0] hcode;
    int               i;
    int               rand_pixels;
    int               rand_frames;

    for (i = 0; i < MAX_COLS; i++) begin
      line_above2[i] = '0;
      line_above1[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 1x1 frames at the pixel extremes, threshold zero
    send_idle_max = 11;
    recv_idle_max = 11;
    apply_setting('0, CFG_W'(1), CFG_W'(1));
    queue_directed(3);
    // 3x3 with a single centre peak just above threshold, corner equal to it
    send_idle_max = 0;
    recv_idle_max = 0;
    apply_setting(CFG_W'(99), CFG_W'(3), CFG_W'(3));
    queue_directed(9);
    // plateau: equal neighbours disqualify every pixel
    send_idle_max = 5;
    apply_setting('0, CFG_W'(2), CFG_W'(2));
    queue_directed(4);
    // zero geometry acts as 1x1; the top threshold cannot be exceeded
    apply_setting('1, 16'hF800, 16'h0000);
    queue_directed(1);
    // one row, equal pair in the middle
    recv_idle_max = 11;
    apply_setting(CFG_W'(1), CFG_W'(4), CFG_W'(1));
    queue_directed(4);

    // Pressure: 1x1 frames each give a result; hold the receiver off while
    // the sender keeps offering, so the result register fills and the input stalls
    send_idle_max = 0;
    recv_idle_max = 3;
    apply_setting(threshold_code(), CFG_W'(1), CFG_W'(1));
    holds_asked++;
    void'(queue_frame(1, 16));

    // Largest width: an oversized code acts as the full line store depth
    send_idle_max = idle_profile();
    recv_idle_max = idle_profile();
    apply_setting(threshold_code(), 16'h07FF, CFG_W'(1));
    void'(queue_frame(MAX_COLS, 1));

    // Random settings, each followed by a few small frames
    rand_pixels = 0;
    rand_frames = 0;
    while (rand_pixels < 480 || rand_frames < 24) begin
      send_idle_max = idle_profile();
      recv_idle_max = idle_profile();
      wcode         = dim_code();
      hcode         = dim_code();
      apply_setting(threshold_code(), wcode, hcode);
      repeat ($urandom_range(1, 4)) begin
        rand_pixels += queue_frame(clamp_dim(wcode[DIM_BITS-1:0], MAX_COLS),
                                   clamp_dim(hcode[DIM_BITS-1:0], MAX_ROWS));
        rand_frames++;
      end
    end

    // Drain, let the block go quiet, then settle the verdict
    wait_drained();
    if (frame_totals_q.size() != 0)
      note_failure($sformatf("%0d frame results never arrived", frame_totals_q.size()));
    $display("summary: %0d pixels, %0d frame results (%0d with maxima), %0d register settings",
             pixels_taken, results_seen, frames_with_peak, settings_applied);
    $display("summary: %0d mismatches, %0d long output hold-offs", failures, holds_served);
    if (failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
